// File: hdl/shift_grid_bilinear_interp_macros.svh
// Assertion macros shared by the shift grid interpolator.
`ifndef SHIFT_GRID_BILINEAR_INTERP_MACROS_SVH
`define SHIFT_GRID_BILINEAR_INTERP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGBI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shift grid assertion failed");

// Next-cycle implication, disabled during reset.
`define SGBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shift grid assertion failed");

`endif

// File: hdl/sgbi_pkg.sv
// Types and constants of the shift grid bilinear interpolator.
package sgbi_pkg;

    localparam int GRID_ROWS_DEF     = 64;
    localparam int GRID_COLUMNS_DEF  = 64;
    localparam int RANGE_SAMPLES_DEF = 8192;

    localparam int Q_MAX_W  = 24;
    localparam int REM_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AZ_ORIGIN  = 3'd0,
        CFG_AZ_SPACING = 3'd1,
        CFG_ROW_COUNT  = 3'd2,
        CFG_RG_ORIGIN  = 3'd3,
        CFG_RG_SPACING = 3'd4,
        CFG_COL_COUNT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        op;
        logic [5:0]  wr_row;
        logic [5:0]  wr_col;
        logic [31:0] rg_val;
        logic [31:0] az_val;
        logic [23:0] line;
        logic [12:0] samp;
    } t_req;

    typedef struct packed {
        logic               op;
        logic [5:0]         wr_row;
        logic [5:0]         wr_col;
        logic [31:0]        rg_val;
        logic [31:0]        az_val;
        logic               az_lo;
        logic               az_hi;
        logic               rg_lo;
        logic               rg_hi;
        logic [REM_W-1:0]   az_rem;
        logic [REM_W-1:0]   rg_rem;
        logic [Q_MAX_W-1:0] az_q;
        logic [Q_MAX_W-1:0] rg_q;
    } t_div;

endpackage

// File: hdl/sgbi_req_if.sv
// Request channel of the shift grid interpolator.
interface sgbi_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  grid_row;
    logic [5:0]  grid_column;
    logic signed [31:0] range_value;
    logic signed [31:0] azimuth_value;
    logic [23:0] azimuth_line;
    logic [12:0] range_sample;

    modport source (output valid, operation, grid_row, grid_column, range_value,
                    azimuth_value, azimuth_line, range_sample, input ready);
    modport sink (input valid, operation, grid_row, grid_column, range_value,
                  azimuth_value, azimuth_line, range_sample, output ready);
endinterface

// File: hdl/sgbi_res_if.sv
// Result channel of the shift grid interpolator.
interface sgbi_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] range_shift;
    logic signed [31:0] azimuth_shift;

    modport source (output valid, range_shift, azimuth_shift, input ready);
    modport sink (input valid, range_shift, azimuth_shift, output ready);
endinterface

// File: hdl/sgbi_bank.sv
// One grid bank: one write port and one registered read port.
module sgbi_bank #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/shift_grid_bilinear_interp.sv
// Top level of the shift grid bilinear interpolator.
//
// Requests arrive on i_req. A request with operation 0 stores one point of the
// range and azimuth grids and gives no result. A request with operation 1
// queries both shifts at an azimuth line and range sample, and its result
// leaves on o_res in request order.
// The six registers are written on i_cfg_we with i_cfg_idx and i_cfg_data;
// the user must do so only while no request is in flight, as the block does not enforce it.
// Throughput is one request per cycle while o_res is not stalled. Most of the
// pipeline is the weight divider, which gives one quotient bit per stage.
// The grids are held in four banks by row and column parity, so the four
// neighbors of a query are read in the same cycle.
// Reset clears the pipeline and sets the registers to their reset values;
// grid contents are undefined until written.
// When o_res is stalled the whole pipeline holds, and i_req.ready falls
// until the waiting result is taken; nothing is lost or repeated.
module shift_grid_bilinear_interp #(
    parameter int GRID_ROWS     = sgbi_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLUMNS  = sgbi_pkg::GRID_COLUMNS_DEF,
    parameter int RANGE_SAMPLES = sgbi_pkg::RANGE_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sgbi_req_if.sink                        i_req,
    sgbi_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [sgbi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgbi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

`include "shift_grid_bilinear_interp_macros.svh"

    localparam int GMAX  = (GRID_ROWS > GRID_COLUMNS) ? GRID_ROWS : GRID_COLUMNS;
    localparam int IW    = $clog2(GMAX);
    localparam int NQ    = IW + 16;
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLUMNS);
    localparam int HR    = (GRID_ROWS + 1) / 2;
    localparam int HC    = (GRID_COLUMNS + 1) / 2;
    localparam int DEPTH = HR * HC;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REM_W = sgbi_pkg::REM_W;

    logic        en;
    logic        r_out_v;
    logic [31:0] r_out_rg, r_out_az;

    assign en          = !r_out_v || o_res.ready;
    assign i_req.ready = en;

    // Configuration registers.
    logic [23:0] r_az_origin;
    logic [15:0] r_az_spacing;
    logic [6:0]  r_row_count;
    logic [12:0] r_rg_origin;
    logic [12:0] r_rg_spacing;
    logic [6:0]  r_col_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_az_origin  <= '0;
            r_az_spacing <= 16'd1;
            r_row_count  <= 7'd2;
            r_rg_origin  <= '0;
            r_rg_spacing <= 13'd1;
            r_col_count  <= 7'd2;
        end else if (i_cfg_we) begin
            case (sgbi_pkg::t_cfg_idx'(i_cfg_idx))
                sgbi_pkg::CFG_AZ_ORIGIN:  r_az_origin  <= i_cfg_data[23:0];
                sgbi_pkg::CFG_AZ_SPACING: r_az_spacing <= i_cfg_data[15:0];
                sgbi_pkg::CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[6:0];
                sgbi_pkg::CFG_RG_ORIGIN:  r_rg_origin  <= i_cfg_data[12:0];
                sgbi_pkg::CFG_RG_SPACING: r_rg_spacing <= i_cfg_data[12:0];
                sgbi_pkg::CFG_COL_COUNT:  r_col_count  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Derived configuration, registered from the configuration registers.
    logic [15:0]   r_az_sp, n_az_sp;
    logic [12:0]   r_rg_sp, n_rg_sp;
    logic [RW-1:0] r_nr_m1, n_nr_m1;
    logic [CW-1:0] r_nc_m1, n_nc_m1;
    logic [40:0]   r_az_last, n_az_last;
    logic [21:0]   r_rg_last, n_rg_last;

    always_comb begin
        int nr;
        int nc;
        nr = (r_row_count < 7'd2) ? 2 :
             ((int'(r_row_count) > GRID_ROWS) ? GRID_ROWS : int'(r_row_count));
        nc = (r_col_count < 7'd2) ? 2 :
             ((int'(r_col_count) > GRID_COLUMNS) ? GRID_COLUMNS : int'(r_col_count));
        n_az_sp   = (r_az_spacing == '0) ? 16'd1 : r_az_spacing;
        n_rg_sp   = (r_rg_spacing == '0) ? 13'd1 : r_rg_spacing;
        n_nr_m1   = RW'(nr - 1);
        n_nc_m1   = CW'(nc - 1);
        n_az_last = 41'(r_az_origin) + 41'(n_az_sp) * 41'(nr - 1);
        n_rg_last = 22'(r_rg_origin) + 22'(n_rg_sp) * 22'(nc - 1);
    end

    always_ff @(posedge i_clk) begin
        r_az_sp   <= n_az_sp;
        r_rg_sp   <= n_rg_sp;
        r_nr_m1   <= n_nr_m1;
        r_nc_m1   <= n_nc_m1;
        r_az_last <= n_az_last;
        r_rg_last <= n_rg_last;
    end

    // Input stage.
    logic            r_s0_v;
    sgbi_pkg::t_req  r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_req.valid;
        end
        if (en) begin
            r_s0.op     <= i_req.operation;
            r_s0.wr_row <= i_req.grid_row;
            r_s0.wr_col <= i_req.grid_column;
            r_s0.rg_val <= i_req.range_value;
            r_s0.az_val <= i_req.azimuth_value;
            r_s0.line   <= i_req.azimuth_line;
            r_s0.samp   <= i_req.range_sample;
        end
    end

    // Offsets, edge flags and dividends.
    sgbi_pkg::t_div n_dv0;

    always_comb begin
        logic [12:0] samp_c;
        logic [23:0] line_d;
        logic [12:0] rg_d;
        samp_c = (int'(r_s0.samp) > RANGE_SAMPLES - 1) ? 13'(RANGE_SAMPLES - 1) : r_s0.samp;
        line_d = r_s0.line - r_az_origin;
        rg_d   = samp_c - r_rg_origin;
        n_dv0        = '0;
        n_dv0.op     = r_s0.op;
        n_dv0.wr_row = r_s0.wr_row;
        n_dv0.wr_col = r_s0.wr_col;
        n_dv0.rg_val = r_s0.rg_val;
        n_dv0.az_val = r_s0.az_val;
        n_dv0.az_lo  = r_s0.line <= r_az_origin;
        n_dv0.az_hi  = 41'(r_s0.line) >= r_az_last;
        n_dv0.rg_lo  = samp_c <= r_rg_origin;
        n_dv0.rg_hi  = 22'(samp_c) >= r_rg_last;
        n_dv0.az_rem = {line_d, 16'b0};
        n_dv0.rg_rem = {11'b0, rg_d, 16'b0};
    end

    // Restoring divider, one quotient bit per stage.
    logic           r_dv_v [NQ+1];
    sgbi_pkg::t_div r_dv   [NQ+1];
    sgbi_pkg::t_div n_dv   [NQ];

    for (genvar k = 0; k < NQ; k++) begin : g_div
        localparam int B = NQ - 1 - k;
        logic [REM_W-1:0] az_div, rg_div;
        logic             az_ge, rg_ge;
        assign az_div = REM_W'(r_az_sp) << B;
        assign rg_div = REM_W'(r_rg_sp) << B;
        assign az_ge  = r_dv[k].az_rem >= az_div;
        assign rg_ge  = r_dv[k].rg_rem >= rg_div;
        always_comb begin
            n_dv[k]      = r_dv[k];
            n_dv[k].az_q = {r_dv[k].az_q[sgbi_pkg::Q_MAX_W-2:0], az_ge};
            n_dv[k].rg_q = {r_dv[k].rg_q[sgbi_pkg::Q_MAX_W-2:0], rg_ge};
            if (az_ge) begin
                n_dv[k].az_rem = r_dv[k].az_rem - az_div;
            end
            if (rg_ge) begin
                n_dv[k].rg_rem = r_dv[k].rg_rem - rg_div;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NQ; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_v[0] <= r_s0_v;
            for (int k = 0; k < NQ; k++) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
        if (en) begin
            r_dv[0] <= n_dv0;
            for (int k = 0; k < NQ; k++) begin
                r_dv[k+1] <= n_dv[k];
            end
        end
    end

    // Index and weight stage.
    logic          r_p_v, r_p_op;
    logic [5:0]    r_p_wrow, r_p_wcol;
    logic [63:0]   r_p_wdata;
    logic [RW-1:0] r_p_r, r_p_r2;
    logic [CW-1:0] r_p_c, r_p_c2;
    logic [15:0]   r_p_rw, r_p_cw;
    logic [RW-1:0] n_r;
    logic [CW-1:0] n_c;
    logic [15:0]   n_rw, n_cw;

    always_comb begin
        sgbi_pkg::t_div d;
        d    = r_dv[NQ];
        n_r  = d.az_lo ? '0 : (d.az_hi ? r_nr_m1 : RW'(d.az_q[NQ-1:16]));
        n_rw = (d.az_lo || d.az_hi) ? '0 : d.az_q[15:0];
        n_c  = d.rg_lo ? '0 : (d.rg_hi ? r_nc_m1 : CW'(d.rg_q[NQ-1:16]));
        n_cw = (d.rg_lo || d.rg_hi) ? '0 : d.rg_q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_dv_v[NQ];
        end
        if (en) begin
            r_p_op    <= r_dv[NQ].op;
            r_p_wrow  <= r_dv[NQ].wr_row;
            r_p_wcol  <= r_dv[NQ].wr_col;
            r_p_wdata <= {r_dv[NQ].rg_val, r_dv[NQ].az_val};
            r_p_r     <= n_r;
            r_p_r2    <= (n_rw != '0) ? n_r + RW'(1) : n_r;
            r_p_c     <= n_c;
            r_p_c2    <= (n_cw != '0) ? n_c + CW'(1) : n_c;
            r_p_rw    <= n_rw;
            r_p_cw    <= n_cw;
        end
    end

    // Grid banks by row and column parity.
    logic [AW-1:0] w_waddr;
    logic          w_wr_ok;
    logic [63:0]   w_rd [4];

    assign w_wr_ok = en && r_p_v && !r_p_op && (int'(r_p_wrow) < GRID_ROWS)
                     && (int'(r_p_wcol) < GRID_COLUMNS);
    assign w_waddr = AW'(int'(r_p_wrow >> 1) * HC + int'(r_p_wcol >> 1));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);
        logic [RW-1:0] rrow;
        logic [CW-1:0] rcol;
        logic [AW-1:0] raddr;
        logic          we;
        assign rrow  = (r_p_r[0] == BSEL[1]) ? r_p_r : r_p_r2;
        assign rcol  = (r_p_c[0] == BSEL[0]) ? r_p_c : r_p_c2;
        assign raddr = AW'(int'(rrow >> 1) * HC + int'(rcol >> 1));
        assign we    = w_wr_ok && ({r_p_wrow[0], r_p_wcol[0]} == BSEL);
        sgbi_bank #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (we),
            .i_waddr (w_waddr),
            .i_wdata (r_p_wdata),
            .i_raddr (raddr),
            .o_rdata (w_rd[b])
        );
    end

    // Read stage metadata, aligned with the registered bank data.
    logic        r_m_v;
    logic [1:0]  r_m_s00, r_m_s10, r_m_s01, r_m_s11;
    logic [15:0] r_m_rw, r_m_cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_p_v && r_p_op;
        end
        if (en) begin
            r_m_s00 <= {r_p_r[0], r_p_c[0]};
            r_m_s10 <= {r_p_r2[0], r_p_c[0]};
            r_m_s01 <= {r_p_r[0], r_p_c2[0]};
            r_m_s11 <= {r_p_r2[0], r_p_c2[0]};
            r_m_rw  <= r_p_rw;
            r_m_cw  <= r_p_cw;
        end
    end

    // Row blend products: range and azimuth for both columns.
    logic               r_x1_v;
    logic [15:0]        r_x1_cw;
    logic signed [49:0] r_x1_pr [8];
    logic signed [49:0] n_x1_pr [8];

    always_comb begin
        logic [63:0] p00, p10, p01, p11;
        logic signed [17:0] w1, w2;
        p00 = w_rd[r_m_s00];
        p10 = w_rd[r_m_s10];
        p01 = w_rd[r_m_s01];
        p11 = w_rd[r_m_s11];
        w2  = $signed({2'b0, r_m_rw});
        w1  = 18'sh10000 - w2;
        n_x1_pr[0] = $signed(p00[63:32]) * w1;
        n_x1_pr[1] = $signed(p10[63:32]) * w2;
        n_x1_pr[2] = $signed(p01[63:32]) * w1;
        n_x1_pr[3] = $signed(p11[63:32]) * w2;
        n_x1_pr[4] = $signed(p00[31:0]) * w1;
        n_x1_pr[5] = $signed(p10[31:0]) * w2;
        n_x1_pr[6] = $signed(p01[31:0]) * w1;
        n_x1_pr[7] = $signed(p11[31:0]) * w2;
    end

    // Row blend sums, floored.
    logic        r_x2_v;
    logic [15:0] r_x2_cw;
    logic [31:0] r_x2_mix [4];
    logic signed [49:0] n_x2_sum [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_x2_sum[i] = r_x1_pr[2*i] + r_x1_pr[2*i+1];
        end
    end

    // Column blend products.
    logic               r_x3_v;
    logic signed [49:0] r_x3_pr [4];
    logic signed [49:0] n_x3_pr [4];

    always_comb begin
        logic signed [17:0] w1, w2;
        w2 = $signed({2'b0, r_x2_cw});
        w1 = 18'sh10000 - w2;
        n_x3_pr[0] = $signed(r_x2_mix[0]) * w1;
        n_x3_pr[1] = $signed(r_x2_mix[1]) * w2;
        n_x3_pr[2] = $signed(r_x2_mix[2]) * w1;
        n_x3_pr[3] = $signed(r_x2_mix[3]) * w2;
    end

    logic signed [49:0] n_rg_sum, n_az_sum;
    assign n_rg_sum = r_x3_pr[0] + r_x3_pr[1];
    assign n_az_sum = r_x3_pr[2] + r_x3_pr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v  <= 1'b0;
            r_x2_v  <= 1'b0;
            r_x3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_x1_v  <= r_m_v;
            r_x2_v  <= r_x1_v;
            r_x3_v  <= r_x2_v;
            r_out_v <= r_x3_v;
        end
        if (en) begin
            r_x1_cw <= r_m_cw;
            for (int i = 0; i < 8; i++) begin
                r_x1_pr[i] <= n_x1_pr[i];
            end
            r_x2_cw <= r_x1_cw;
            for (int i = 0; i < 4; i++) begin
                r_x2_mix[i] <= n_x2_sum[i][47:16];
                r_x3_pr[i]  <= n_x3_pr[i];
            end
            r_out_rg <= n_rg_sum[47:16];
            r_out_az <= n_az_sum[47:16];
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.range_shift   = r_out_rg;
    assign o_res.azimuth_shift = r_out_az;

    `SGBI_ASSERT_IMPL(a_row_weight, i_clk, i_rst_n, r_p_v && r_p_op && (r_p_rw != '0), r_p_r < r_nr_m1)
    `SGBI_ASSERT_IMPL(a_col_weight, i_clk, i_rst_n, r_p_v && r_p_op && (r_p_cw != '0), r_p_c < r_nc_m1)
    `SGBI_ASSERT_IMPL(a_ready_stall, i_clk, i_rst_n, !i_req.ready, r_out_v && !o_res.ready)
    `SGBI_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, r_out_v && !o_res.ready, r_out_v && $stable(r_out_rg) && $stable(r_out_az))

endmodule

// File: test/shift_grid_bilinear_interp_tb.sv
// Self-checking testbench of the shift grid bilinear interpolator with its own shift predictor.
typedef struct {
    logic [31:0] rg;
    logic [31:0] az;
} t_shift_pair;

class shift_scoreboard;
    logic [31:0] rg_grid [4096];
    logic [31:0] az_grid [4096];
    bit          written [4096];
    logic [23:0] az_org;
    logic [15:0] az_sp;
    logic [6:0]  rows;
    logic [12:0] rg_org;
    logic [12:0] rg_sp;
    logic [6:0]  cols;
    t_shift_pair pending [$];
    int          errors;

    function new();
        az_org = 0;
        az_sp  = 1;
        rows   = 2;
        rg_org = 0;
        rg_sp  = 1;
        cols   = 2;
        errors = 0;
        foreach (written[i]) written[i] = 0;
    endfunction

    function void set_reg(sgbi_pkg::t_cfg_idx idx, logic [23:0] v);
        case (idx)
            sgbi_pkg::CFG_AZ_ORIGIN:  az_org = v[23:0];
            sgbi_pkg::CFG_AZ_SPACING: az_sp  = v[15:0];
            sgbi_pkg::CFG_ROW_COUNT:  rows   = v[6:0];
            sgbi_pkg::CFG_RG_ORIGIN:  rg_org = v[12:0];
            sgbi_pkg::CFG_RG_SPACING: rg_sp  = v[12:0];
            sgbi_pkg::CFG_COL_COUNT:  cols   = v[6:0];
            default: ;
        endcase
    endfunction

    function int clamp_count(int c);
        if (c < 2) return 2;
        if (c > 64) return 64;
        return c;
    endfunction

    function int n_rows();
        return clamp_count(rows);
    endfunction

    function int n_cols();
        return clamp_count(cols);
    endfunction

    function longint sp_az();
        return (az_sp == 0) ? 1 : az_sp;
    endfunction

    function longint sp_rg();
        return (rg_sp == 0) ? 1 : rg_sp;
    endfunction

    function void locate(longint p, longint o, longint s, int n, output int idx,
                         output longint w);
        longint last;
        last = o + s * (n - 1);
        if (p <= o) begin
            idx = 0;
            w   = 0;
        end else if (p >= last) begin
            idx = n - 1;
            w   = 0;
        end else begin
            idx = int'((p - o) / s);
            w   = (((p - o) % s) * 65536) / s;
        end
    endfunction

    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint w);
        longint s;
        s = longint'($signed(a)) * (65536 - w) + longint'($signed(b)) * w;
        s = s >>> 16;
        return s[31:0];
    endfunction

    function logic [31:0] mix(bit is_rg, int r, longint rw, int c, longint cw);
        int          r2;
        int          c2;
        logic [31:0] lo;
        logic [31:0] hi;
        r2 = (rw != 0) ? r + 1 : r;
        c2 = (cw != 0) ? c + 1 : c;
        if (is_rg) begin
            lo = blend(rg_grid[r*64+c], rg_grid[r2*64+c], rw);
            hi = blend(rg_grid[r*64+c2], rg_grid[r2*64+c2], rw);
        end else begin
            lo = blend(az_grid[r*64+c], az_grid[r2*64+c], rw);
            hi = blend(az_grid[r*64+c2], az_grid[r2*64+c2], rw);
        end
        return blend(lo, hi, cw);
    endfunction

    function void note_request(logic op, logic [5:0] row, logic [5:0] col,
                               logic [31:0] rv, logic [31:0] av,
                               logic [23:0] line, logic [12:0] samp);
        int          r;
        int          c;
        longint      rw;
        longint      cw;
        t_shift_pair e;
        if (op == 1'b0) begin
            rg_grid[row*64+col] = rv;
            az_grid[row*64+col] = av;
            written[row*64+col] = 1;
        end else begin
            locate(line, az_org, sp_az(), n_rows(), r, rw);
            locate(samp, rg_org, sp_rg(), n_cols(), c, cw);
            e.rg = mix(1, r, rw, c, cw);
            e.az = mix(0, r, rw, c, cw);
            pending.push_back(e);
        end
    endfunction

    function void check_result(logic [31:0] rg, logic [31:0] az);
        t_shift_pair e;
        if (pending.size() == 0) begin
            $error("unexpected result range_shift %h azimuth_shift %h", rg, az);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (rg !== e.rg) begin
            $error("range_shift expected %h actual %h", e.rg, rg);
            errors++;
        end
        if (az !== e.az) begin
            $error("azimuth_shift expected %h actual %h", e.az, az);
            errors++;
        end
    endfunction
endclass

module shift_grid_bilinear_interp_tb;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [sgbi_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [sgbi_pkg::CFG_DATA_W-1:0] cfg_data;
    int                              tx_idle;
    int                              rx_idle;
    int                              accepted;

    shift_scoreboard sb;

    sgbi_req_if req_ch ();
    sgbi_res_if res_ch ();

    shift_grid_bilinear_interp u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result(res_ch.range_shift, res_ch.azimuth_shift);
        end
    end

    task automatic send(logic op, logic [5:0] row, logic [5:0] col, logic [31:0] rv,
                        logic [31:0] av, logic [23:0] line, logic [12:0] samp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.grid_row      <= row;
        req_ch.grid_column   <= col;
        req_ch.range_value   <= rv;
        req_ch.azimuth_value <= av;
        req_ch.azimuth_line  <= line;
        req_ch.range_sample  <= samp;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, row, col, rv, av, line, samp);
        accepted++;
        if (accepted == 220) begin
            tx_idle = 49;
            rx_idle = 24;
        end else if (accepted == 440) begin
            tx_idle = 0;
            rx_idle = 0;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic configure(logic [23:0] azo, logic [23:0] azs, logic [23:0] nr,
                             logic [23:0] rgo, logic [23:0] rgs, logic [23:0] nc);
        logic [23:0] vals [6];
        vals = '{azo, azs, nr, rgo, rgs, nc};
        for (int i = 0; i < 6; i++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= sgbi_pkg::t_cfg_idx'(i);
            cfg_data <= vals[i];
            sb.set_reg(sgbi_pkg::t_cfg_idx'(i), vals[i]);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_grid();
        for (int r = 0; r < sb.n_rows(); r++) begin
            for (int c = 0; c < sb.n_cols(); c++) begin
                if (!sb.written[r*64+c])
                    send(OP_WRITE, r, c, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic random_query();
        longint sp;
        longint p;
        logic [23:0] line;
        logic [12:0] samp;
        sp = sb.sp_az();
        p = longint'(sb.az_org) - sp + $urandom_range(0, sp * (sb.n_rows() + 1));
        line = (p < 0) ? 0 : (p > 24'hFFFFFF) ? 24'hFFFFFF : p[23:0];
        if ($urandom_range(0, 7) == 0) line = $urandom;
        sp = sb.sp_rg();
        p = longint'(sb.rg_org) - sp + $urandom_range(0, sp * (sb.n_cols() + 1));
        samp = (p < 0) ? 0 : (p > 8191) ? 13'h1FFF : p[12:0];
        if ($urandom_range(0, 7) == 0) samp = $urandom;
        send(OP_QUERY, $urandom, $urandom, $urandom, $urandom, line, samp);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send(OP_WRITE, $urandom_range(0, sb.n_rows() - 1),
                     $urandom_range(0, sb.n_cols() - 1), $urandom, $urandom,
                     $urandom, $urandom);
            else
                random_query();
        end
        drain();
    endtask

    initial begin
        sb = new();
        accepted = 0;
        tx_idle = 24;
        rx_idle = 49;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_WRITE;
        req_ch.grid_row = '0;
        req_ch.grid_column = '0;
        req_ch.range_value = '0;
        req_ch.azimuth_value = '0;
        req_ch.azimuth_line = '0;
        req_ch.range_sample = '0;
        res_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(0, 1, 2, 0, 1, 2);
        send(OP_WRITE, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send(OP_WRITE, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send(OP_WRITE, 1, 0, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send(OP_WRITE, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send(OP_QUERY, 0, 0, 0, 0, 24'd0, 13'd0);
        send(OP_QUERY, 0, 0, 0, 0, 24'hFFFFFF, 13'h1FFF);
        send(OP_QUERY, 0, 0, 0, 0, 24'd1, 13'd0);
        drain();

        // Fractional weights on both axes, then queries across every edge.
        configure(100, 7, 5, 50, 13, 4);
        fill_grid();
        send(OP_QUERY, 0, 0, 0, 0, 24'd99, 13'd49);
        send(OP_QUERY, 0, 0, 0, 0, 24'd100, 13'd50);
        send(OP_QUERY, 0, 0, 0, 0, 24'd103, 13'd56);
        send(OP_QUERY, 0, 0, 0, 0, 24'd128, 13'd89);
        send(OP_QUERY, 0, 0, 0, 0, 24'd127, 13'd88);
        send(OP_QUERY, 0, 0, 0, 0, 24'd500, 13'd8191);
        send(OP_WRITE, 63, 63, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0);
        drain();
        random_phase(90);

        // All rows in use with widest spacing.
        configure(24'hFFFFFF, 65535, 64, 8191, 8191, 2);
        fill_grid();
        random_phase(50);

        // Zero spacing and counts below and above the legal range.
        configure(0, 0, 0, 0, 0, 1);
        random_phase(50);
        configure(3000, 37, 127, 200, 111, 2);
        random_phase(50);
        configure(17, 1, 2, 5, 1, 64);
        fill_grid();
        random_phase(50);
        configure(3000, 37, 2, 200, 111, 127);
        random_phase(40);
        configure(24'h800000, 65535, 9, 4096, 1000, 6);
        fill_grid();
        random_phase(40);
        drain();

        if (sb.errors == 0)
            $display("shift_grid_bilinear_interp_tb: done, clean");
        else
            $display("shift_grid_bilinear_interp_tb: done, errors");
        $finish;
    end

    initial begin
        #(20 * 2_000_000);
        $display("shift_grid_bilinear_interp_tb: done, errors");
        $finish;
    end
endmodule
